@@ hdl/rotation_key_image_decrypt_top_defines.svh @@
// Assertion macros for the key-rotation image decrypt block.
`ifndef ROTATION_KEY_IMAGE_DECRYPT_TOP_DEFINES_SVH
`define ROTATION_KEY_IMAGE_DECRYPT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define RKID_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rkid: implication failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define RKID_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rkid: next-cycle implication failed");

`endif

@@ hdl/rkid_pkg.sv @@
// Shared types, constants and the index function of the key-rotation image decrypt block.
`timescale 1ns / 1ps
`default_nettype none
package rkid_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int IDX_W     = 6;
    localparam int SIZE_W    = 7;
    localparam int KEY_W     = 8;
    localparam int PIX_W     = 8;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam int KEY_DEPTH = MAX_ROWS + MAX_COLS;
    localparam int PIX_DEPTH = MAX_ROWS * MAX_COLS;

    localparam int MOD_STEPS = KEY_W / 2;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    localparam logic [CMD_W-1:0] CMD_ROW_KEY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COL_KEY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PIXEL   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd8;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
        logic [KEY_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             out_of_range;
    } t_out_word;

    // Move pos by a key already reduced below size; odd keys move down, even up.
    function automatic logic [IDX_W-1:0] shift_idx(
        input logic [IDX_W-1:0]  pos,
        input logic [SIZE_W-1:0] k,
        input logic [SIZE_W-1:0] size,
        input logic              odd
    );
        logic [SIZE_W:0] t;
        if (odd) begin
            t = {{(SIZE_W+1-IDX_W){1'b0}}, pos} + {1'b0, size} - {1'b0, k};
        end else begin
            t = {{(SIZE_W+1-IDX_W){1'b0}}, pos} + {1'b0, k};
        end
        if (t >= {1'b0, size}) begin
            t = t - {1'b0, size};
        end
        return t[IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ hdl/rkid_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rkid_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/rkid_mod.sv @@
// Iterative key modulo unit: two remainder bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rkid_mod (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rkid_pkg::KEY_W-1:0]  i_dividend,
    input  wire logic [rkid_pkg::SIZE_W-1:0] i_divisor,
    output logic                             o_done,
    output logic      [rkid_pkg::SIZE_W-1:0] o_rem
);

    logic                           r_busy;
    logic                           r_done;
    logic [rkid_pkg::MOD_CNT_W-1:0] r_cnt;
    logic [rkid_pkg::KEY_W-1:0]     r_num;
    logic [rkid_pkg::SIZE_W-1:0]    r_rem;
    logic [rkid_pkg::SIZE_W-1:0]    r_div;
    logic [rkid_pkg::SIZE_W-1:0]    w_rem1;
    logic [rkid_pkg::SIZE_W-1:0]    w_rem2;

    function automatic logic [rkid_pkg::SIZE_W-1:0] rem_step(
        input logic [rkid_pkg::SIZE_W-1:0] rem,
        input logic                        nbit,
        input logic [rkid_pkg::SIZE_W-1:0] dv
    );
        logic [rkid_pkg::SIZE_W:0] t;
        t = {rem, nbit};
        if (t >= {1'b0, dv}) begin
            t = t - {1'b0, dv};
        end
        return t[rkid_pkg::SIZE_W-1:0];
    endfunction

    assign w_rem1 = rem_step(r_rem, r_num[rkid_pkg::KEY_W-1], r_div);
    assign w_rem2 = rem_step(w_rem1, r_num[rkid_pkg::KEY_W-2], r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rkid_pkg::MOD_CNT_W'(rkid_pkg::MOD_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[rkid_pkg::KEY_W-3:0], 2'b00};
            r_rem <= w_rem2;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

@@ hdl/rotation_key_image_decrypt_top.sv @@
// Top level of the key-rotation image decrypt block: command sequencer, key and pixel stores.
`timescale 1ns / 1ps
`default_nettype none
`include "rotation_key_image_decrypt_top_defines.svh"
// Load commands write a row key, a column key or an encrypted pixel in the cycle they are
// taken, so loads stream at one word per cycle while no read is in progress. A read walks
// a fixed sequence: row key read from the key RAM, reduction modulo the column count in the
// two-bit-per-cycle modulo unit, column key read, reduction modulo the row count, pixel RAM
// read and result capture; no new word is taken until the result is captured. A read outside
// the configured size skips the key and pixel steps and answers out of range. A stalled
// output only holds the next read. The key and pixel stores hold garbage until loaded;
// reading an unloaded entry gives an unspecified pixel. Size registers clamp to 1..64 on
// write. Configuration must be written only while idle; the block does not enforce it.
module rotation_key_image_decrypt_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire rkid_pkg::t_in_word             i_in_word,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output rkid_pkg::t_out_word                 o_out_word,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [rkid_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [rkid_pkg::SIZE_W-1:0]    i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RKEY = 3'd1;
    localparam logic [2:0] S_RMOD = 3'd2;
    localparam logic [2:0] S_CKEY = 3'd3;
    localparam logic [2:0] S_CMOD = 3'd4;
    localparam logic [2:0] S_PIX  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam int KEY_AW = $clog2(rkid_pkg::KEY_DEPTH);
    localparam int PIX_AW = $clog2(rkid_pkg::PIX_DEPTH);

    logic [2:0]                    r_state;
    logic [2:0]                    n_state;
    logic [rkid_pkg::SIZE_W-1:0]   r_rows;
    logic [rkid_pkg::SIZE_W-1:0]   r_cols;
    logic [rkid_pkg::IDX_W-1:0]    r_ri;
    logic [rkid_pkg::IDX_W-1:0]    r_ci;
    logic [rkid_pkg::IDX_W-1:0]    r_c;
    logic                          r_odd;
    rkid_pkg::t_out_word           r_res;
    logic                          r_out_valid;
    logic                          n_out_valid;
    rkid_pkg::t_out_word           r_out_word;

    logic                          w_in_acc;
    logic                          w_in_range;
    logic                          w_out_load;
    logic                          w_key_we;
    logic [KEY_AW-1:0]             w_key_waddr;
    logic                          w_key_re;
    logic [KEY_AW-1:0]             w_key_raddr;
    logic [rkid_pkg::KEY_W-1:0]    w_key_rdata;
    logic                          w_pix_we;
    logic                          w_pix_re;
    logic [PIX_AW-1:0]             w_pix_raddr;
    logic [rkid_pkg::PIX_W-1:0]    w_pix_rdata;
    logic                          w_mod_start;
    logic [rkid_pkg::SIZE_W-1:0]   w_mod_div;
    logic                          w_mod_done;
    logic [rkid_pkg::SIZE_W-1:0]   w_mod_rem;
    logic [rkid_pkg::IDX_W-1:0]    w_c_next;
    logic [rkid_pkg::IDX_W-1:0]    w_r_next;

    function automatic logic [rkid_pkg::SIZE_W-1:0] clamp_size(
        input logic [rkid_pkg::SIZE_W-1:0] v,
        input logic [rkid_pkg::SIZE_W-1:0] maxv
    );
        logic [rkid_pkg::SIZE_W-1:0] s;
        s = v;
        if (v == '0) begin
            s = rkid_pkg::SIZE_W'(1);
        end else if (v > maxv) begin
            s = maxv;
        end
        return s;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_in_range = ({1'b0, i_in_word.row_index} < r_rows)
                     && ({1'b0, i_in_word.col_index} < r_cols);
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    assign w_c_next = rkid_pkg::shift_idx(r_ci, w_mod_rem, r_cols, r_odd);
    assign w_r_next = rkid_pkg::shift_idx(r_ri, w_mod_rem, r_rows, r_odd);

    assign w_key_we    = w_in_acc && ((i_in_word.command == rkid_pkg::CMD_ROW_KEY)
                                   || (i_in_word.command == rkid_pkg::CMD_COL_KEY));
    assign w_key_waddr = (i_in_word.command == rkid_pkg::CMD_ROW_KEY)
                       ? {1'b0, i_in_word.row_index} : {1'b1, i_in_word.col_index};
    assign w_pix_we    = w_in_acc && (i_in_word.command == rkid_pkg::CMD_PIXEL);

    assign w_key_re    = (w_in_acc && (i_in_word.command == rkid_pkg::CMD_READ) && w_in_range)
                      || ((r_state == S_RMOD) && w_mod_done);
    assign w_key_raddr = (r_state == S_RMOD) ? {1'b1, w_c_next} : {1'b0, i_in_word.row_index};

    assign w_pix_re    = (r_state == S_CMOD) && w_mod_done;
    assign w_pix_raddr = {w_r_next, r_c};

    assign w_mod_start = (r_state == S_RKEY) || (r_state == S_CKEY);
    assign w_mod_div   = (r_state == S_RKEY) ? r_cols : r_rows;

    rkid_ram #(
        .DEPTH (rkid_pkg::KEY_DEPTH),
        .WIDTH (rkid_pkg::KEY_W)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (w_key_waddr),
        .i_wdata (i_in_word.value),
        .i_re    (w_key_re),
        .i_raddr (w_key_raddr),
        .o_rdata (w_key_rdata)
    );

    rkid_ram #(
        .DEPTH (rkid_pkg::PIX_DEPTH),
        .WIDTH (rkid_pkg::PIX_W)
    ) u_pix_ram (
        .i_clk   (i_clk),
        .i_we    (w_pix_we),
        .i_waddr ({i_in_word.row_index, i_in_word.col_index}),
        .i_wdata (i_in_word.value),
        .i_re    (w_pix_re),
        .i_raddr (w_pix_raddr),
        .o_rdata (w_pix_rdata)
    );

    rkid_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_key_rdata),
        .i_divisor  (w_mod_div),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in_word.command == rkid_pkg::CMD_READ)) begin
                    n_state = w_in_range ? S_RKEY : S_OUT;
                end
            end
            S_RKEY: n_state = S_RMOD;
            S_RMOD: begin
                if (w_mod_done) begin
                    n_state = S_CKEY;
                end
            end
            S_CKEY: n_state = S_CMOD;
            S_CMOD: begin
                if (w_mod_done) begin
                    n_state = S_PIX;
                end
            end
            S_PIX: n_state = S_OUT;
            S_OUT: begin
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rows      <= rkid_pkg::SIZE_RESET;
            r_cols      <= rkid_pkg::SIZE_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    rkid_pkg::CFG_NUM_ROWS: begin
                        r_rows <= clamp_size(i_cfg_data, rkid_pkg::SIZE_W'(rkid_pkg::MAX_ROWS));
                    end
                    rkid_pkg::CFG_NUM_COLS: begin
                        r_cols <= clamp_size(i_cfg_data, rkid_pkg::SIZE_W'(rkid_pkg::MAX_COLS));
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ri  <= i_in_word.row_index;
            r_ci  <= i_in_word.col_index;
            r_res <= '{pixel: '0, out_of_range: 1'b1};
        end
        if (w_mod_start) begin
            r_odd <= w_key_rdata[0];
        end
        if ((r_state == S_RMOD) && w_mod_done) begin
            r_c <= w_c_next;
        end
        if (r_state == S_PIX) begin
            r_res <= '{pixel: ~w_pix_rdata, out_of_range: 1'b0};
        end
        if (w_out_load) begin
            r_out_word <= r_res;
        end
    end

    `RKID_ASSERT_IMP(a_mod_done_state, w_mod_done, (r_state == S_RMOD) || (r_state == S_CMOD))
    `RKID_ASSERT_IMP(a_oor_zero, o_out_valid && o_out_word.out_of_range, o_out_word.pixel == '0)
    `RKID_ASSERT_IMP(a_size_legal, r_state == S_IDLE, (r_rows != '0) && (r_cols != '0) && (r_rows <= rkid_pkg::SIZE_W'(rkid_pkg::MAX_ROWS)) && (r_cols <= rkid_pkg::SIZE_W'(rkid_pkg::MAX_COLS)))
    `RKID_ASSERT_NEXT(a_out_loads, (r_state == S_OUT) && !o_out_valid, o_out_valid && (r_state == S_IDLE))

endmodule
`default_nettype wire
